>>> rtl/core/h2r_pkg.sv
// Shared types and constants for the HSV to RGB converter.
package h2r_pkg;

    // Unsigned fixed point, 12 fraction bits, 4096 = 1.0
    typedef logic [12:0] fix_t;

    localparam fix_t ONE_FIX = 13'd4096;

    // Hue in degrees times 64: full turn and one 60 degree sector
    localparam logic signed [16:0] FULL_TURN     = 17'sd23040;
    localparam logic signed [16:0] TWO_TURNS     = 17'sd46080;
    localparam logic [14:0]        SECTOR_SIZE   = 15'd3840;

    // Sector start points within the wrapped hue
    localparam logic [14:0] SECTOR_1_BASE = 15'd3840;
    localparam logic [14:0] SECTOR_2_BASE = 15'd7680;
    localparam logic [14:0] SECTOR_3_BASE = 15'd11520;
    localparam logic [14:0] SECTOR_4_BASE = 15'd15360;
    localparam logic [14:0] SECTOR_5_BASE = 15'd19200;

    // f = rem * 16 / 15 computed as (rem * FRAC_RECIP) >> FRAC_SHIFT
    localparam logic [15:0] FRAC_RECIP = 16'd34953;
    localparam int          FRAC_SHIFT = 15;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    // Hue split result passed to the shading stages
    typedef struct packed {
        sector_t     sector;
        logic [11:0] rem;
        fix_t        sat;
        fix_t        val;
        fix_t        p;
    } split_t;

    // Shading result passed to the color select stage
    typedef struct packed {
        sector_t sector;
        fix_t    val;
        fix_t    p;
        fix_t    q;
        fix_t    t;
    } shade_t;

    // Clamp a 13-bit fixed point value to 1.0
    function automatic fix_t clamp_one(input fix_t x);
        fix_t r;
        r = (x > ONE_FIX) ? ONE_FIX : x;
        return r;
    endfunction

endpackage

>>> rtl/core/h2r_hue_unit.sv
// Hue wrap, sector split and p product: two pipeline stages.
module h2r_hue_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   hue,
    input  h2r_pkg::fix_t        sat,
    input  h2r_pkg::fix_t        val,
    output logic                 out_valid,
    input  logic                 out_ready,
    output h2r_pkg::split_t      split
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [14:0]       s1_hue_reg;
    logic [14:0]       s1_hue_next;
    h2r_pkg::fix_t     s1_sat_reg;
    h2r_pkg::fix_t     s1_val_reg;
    logic              s1_ready;

    logic              s2_valid_reg;
    logic              s2_valid_next;
    h2r_pkg::split_t   s2_reg;
    h2r_pkg::split_t   s2_next;
    logic              s2_ready;

    logic signed [16:0] hue_ext;
    logic signed [16:0] hue_wrap;
    logic [14:0]        base;
    logic [14:0]        rem_full;
    logic [25:0]        p_prod;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: wrap hue into one turn
    always_comb
    begin
        hue_ext = {hue[15], hue};
        if (hue_ext >= h2r_pkg::FULL_TURN)
        begin
            hue_wrap = hue_ext - h2r_pkg::FULL_TURN;
        end
        else if (hue_ext >= 17'sd0)
        begin
            hue_wrap = hue_ext;
        end
        else if (hue_ext >= -h2r_pkg::FULL_TURN)
        begin
            hue_wrap = hue_ext + h2r_pkg::FULL_TURN;
        end
        else
        begin
            hue_wrap = hue_ext + h2r_pkg::TWO_TURNS;
        end
        s1_hue_next   = hue_wrap[14:0];
        s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    end

    // Stage 2: sector, remainder within the sector, and p
    always_comb
    begin
        s2_next.sat = s1_sat_reg;
        s2_next.val = s1_val_reg;
        if (s1_hue_reg >= h2r_pkg::SECTOR_5_BASE)
        begin
            s2_next.sector = h2r_pkg::SECTOR_5;
            base           = h2r_pkg::SECTOR_5_BASE;
        end
        else if (s1_hue_reg >= h2r_pkg::SECTOR_4_BASE)
        begin
            s2_next.sector = h2r_pkg::SECTOR_4;
            base           = h2r_pkg::SECTOR_4_BASE;
        end
        else if (s1_hue_reg >= h2r_pkg::SECTOR_3_BASE)
        begin
            s2_next.sector = h2r_pkg::SECTOR_3;
            base           = h2r_pkg::SECTOR_3_BASE;
        end
        else if (s1_hue_reg >= h2r_pkg::SECTOR_2_BASE)
        begin
            s2_next.sector = h2r_pkg::SECTOR_2;
            base           = h2r_pkg::SECTOR_2_BASE;
        end
        else if (s1_hue_reg >= h2r_pkg::SECTOR_1_BASE)
        begin
            s2_next.sector = h2r_pkg::SECTOR_1;
            base           = h2r_pkg::SECTOR_1_BASE;
        end
        else
        begin
            s2_next.sector = h2r_pkg::SECTOR_0;
            base           = 15'd0;
        end
        rem_full    = s1_hue_reg - base;
        s2_next.rem = rem_full[11:0];
        p_prod      = {13'd0, s1_val_reg} * {13'd0, h2r_pkg::ONE_FIX - s1_sat_reg};
        s2_next.p   = p_prod[24:12];
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_hue_reg <= s1_hue_next;
            s1_sat_reg <= h2r_pkg::clamp_one(sat);
            s1_val_reg <= h2r_pkg::clamp_one(val);
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign split     = s2_reg;

endmodule

>>> rtl/core/h2r_shade_unit.sv
// Fraction, scaled saturation and q/t products: three pipeline stages.
module h2r_shade_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  h2r_pkg::split_t   split,
    output logic              out_valid,
    input  logic              out_ready,
    output h2r_pkg::shade_t   shade
);

    typedef struct packed {
        h2r_pkg::sector_t sector;
        logic [11:0]      frac;
        h2r_pkg::fix_t    sat;
        h2r_pkg::fix_t    val;
        h2r_pkg::fix_t    p;
    } frac_stage_t;

    typedef struct packed {
        h2r_pkg::sector_t sector;
        h2r_pkg::fix_t    sf;
        h2r_pkg::fix_t    sfc;
        h2r_pkg::fix_t    val;
        h2r_pkg::fix_t    p;
    } sat_stage_t;

    logic             s3_valid_reg;
    logic             s3_valid_next;
    frac_stage_t      s3_reg;
    frac_stage_t      s3_next;
    logic             s3_ready;

    logic             s4_valid_reg;
    logic             s4_valid_next;
    sat_stage_t       s4_reg;
    sat_stage_t       s4_next;
    logic             s4_ready;

    logic             s5_valid_reg;
    logic             s5_valid_next;
    h2r_pkg::shade_t  s5_reg;
    h2r_pkg::shade_t  s5_next;
    logic             s5_ready;

    logic [27:0]      frac_prod;
    h2r_pkg::fix_t    frac_comp;
    logic [25:0]      sf_prod;
    logic [25:0]      sfc_prod;
    logic [25:0]      q_prod;
    logic [25:0]      t_prod;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;

    // Stage 3: f = rem * 4096 / 3840 by reciprocal multiply
    always_comb
    begin
        frac_prod      = {16'd0, split.rem} * {12'd0, h2r_pkg::FRAC_RECIP};
        s3_next.frac   = frac_prod[h2r_pkg::FRAC_SHIFT +: 12];
        s3_next.sector = split.sector;
        s3_next.sat    = split.sat;
        s3_next.val    = split.val;
        s3_next.p      = split.p;
        s3_valid_next  = s3_ready ? in_valid : s3_valid_reg;
    end

    // Stage 4: sat * f and sat * (1 - f)
    always_comb
    begin
        frac_comp      = h2r_pkg::ONE_FIX - {1'b0, s3_reg.frac};
        sf_prod        = {13'd0, s3_reg.sat} * {14'd0, s3_reg.frac};
        sfc_prod       = {13'd0, s3_reg.sat} * {13'd0, frac_comp};
        s4_next.sf     = sf_prod[24:12];
        s4_next.sfc    = sfc_prod[24:12];
        s4_next.sector = s3_reg.sector;
        s4_next.val    = s3_reg.val;
        s4_next.p      = s3_reg.p;
        s4_valid_next  = s4_ready ? s3_valid_reg : s4_valid_reg;
    end

    // Stage 5: q and t
    always_comb
    begin
        q_prod         = {13'd0, s4_reg.val} * {13'd0, h2r_pkg::ONE_FIX - s4_reg.sf};
        t_prod         = {13'd0, s4_reg.val} * {13'd0, h2r_pkg::ONE_FIX - s4_reg.sfc};
        s5_next.q      = q_prod[24:12];
        s5_next.t      = t_prod[24:12];
        s5_next.sector = s4_reg.sector;
        s5_next.val    = s4_reg.val;
        s5_next.p      = s4_reg.p;
        s5_valid_next  = s5_ready ? s4_valid_reg : s5_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s3_ready)
        begin
            s3_reg <= s3_next;
        end
        if (s3_valid_reg && s4_ready)
        begin
            s4_reg <= s4_next;
        end
        if (s4_valid_reg && s5_ready)
        begin
            s5_reg <= s5_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign shade     = s5_reg;

endmodule

>>> rtl/core/h2r_color_mux.sv
// Sector-driven placement of val, p, q and t onto the output register.
module h2r_color_mux
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  h2r_pkg::shade_t   shade,
    output logic              out_valid,
    input  logic              out_ready,
    output h2r_pkg::fix_t     red,
    output h2r_pkg::fix_t     green,
    output h2r_pkg::fix_t     blue
);

    logic           valid_reg;
    logic           valid_next;
    h2r_pkg::fix_t  red_reg;
    h2r_pkg::fix_t  red_next;
    h2r_pkg::fix_t  green_reg;
    h2r_pkg::fix_t  green_next;
    h2r_pkg::fix_t  blue_reg;
    h2r_pkg::fix_t  blue_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        case (shade.sector)
            h2r_pkg::SECTOR_0:
            begin
                red_next = shade.val; green_next = shade.t;   blue_next = shade.p;
            end
            h2r_pkg::SECTOR_1:
            begin
                red_next = shade.q;   green_next = shade.val; blue_next = shade.p;
            end
            h2r_pkg::SECTOR_2:
            begin
                red_next = shade.p;   green_next = shade.val; blue_next = shade.t;
            end
            h2r_pkg::SECTOR_3:
            begin
                red_next = shade.p;   green_next = shade.q;   blue_next = shade.val;
            end
            h2r_pkg::SECTOR_4:
            begin
                red_next = shade.t;   green_next = shade.p;   blue_next = shade.val;
            end
            default:
            begin
                red_next = shade.val; green_next = shade.p;   blue_next = shade.q;
            end
        endcase
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

>>> rtl/core/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB pixel converter.
//
//   Channel   Direction  Handshake             Payload
//   -------   ---------  --------------------  -----------------------------
//   input     in         in_valid / in_ready   hue (s16), sat (u13), val (u13)
//   output    out        out_valid / out_ready red, green, blue (u13 each)
//
// One pixel is accepted in every clock cycle unless a stall backs up to the
// input. A pixel passes six register stages (wrap, split, fraction, scaled
// saturation, q/t products, color select), and the color select register
// drives out_valid and the three color outputs.
// Reset clears the valid bit of every stage; payload registers hold junk
// until loaded. Each stage holds while the stage after it is full and
// stalled, so a stall at the output backs up stage by stage and empty
// stages keep accepting: nothing is dropped or repeated.
module hsv_to_rgb_converter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  hue,
    input  logic [12:0]         sat,
    input  logic [12:0]         val,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [12:0]         red,
    output logic [12:0]         green,
    output logic [12:0]         blue
);

    // Hue unit to shading unit
    logic             split_valid;
    logic             split_ready;
    h2r_pkg::split_t  split;

    // Shading unit to color select
    logic             shade_valid;
    logic             shade_ready;
    h2r_pkg::shade_t  shade;

    // Wrap hue into one turn, find the sector and remainder, form p
    h2r_hue_unit u_hue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .hue       (hue),
        .sat       (sat),
        .val       (val),
        .out_valid (split_valid),
        .out_ready (split_ready),
        .split     (split)
    );

    // Derive the sector fraction, then q and t
    h2r_shade_unit u_shade
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_valid),
        .in_ready  (split_ready),
        .split     (split),
        .out_valid (shade_valid),
        .out_ready (shade_ready),
        .shade     (shade)
    );

    // Place val, p, q and t on the color channels and hold the result
    h2r_color_mux u_mux
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (shade_valid),
        .in_ready  (shade_ready),
        .shade     (shade),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the HSV to RGB pixel converter.
`timescale 1ns / 1ps

module testbench;

    // One HSV pixel waiting to be offered on the input channel
    typedef struct {
        logic signed [15:0] hue;
        h2r_pkg::fix_t      sat;
        h2r_pkg::fix_t      val;
    } hsv_pixel_t;

    // One RGB pixel expected on the output channel
    typedef struct {
        h2r_pkg::fix_t red;
        h2r_pkg::fix_t green;
        h2r_pkg::fix_t blue;
    } rgb_pixel_t;

    localparam int RANDOM_PIXELS = 900;
    localparam int TAIL_PIXELS   = 120;   // final stretch driven with no idling
    localparam int HOLD_AFTER    = 300;   // transfers before the long output hold-off
    localparam int HOLD_CYCLES   = 120;
    localparam int DRAIN_CYCLES  = 20;    // pipeline is six stages deep

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic signed [15:0] hue       = '0;
    logic [12:0]        sat       = '0;
    logic [12:0]        val       = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [12:0]        red;
    logic [12:0]        green;
    logic [12:0]        blue;

    hsv_pixel_t pending_pixels[$];
    rgb_pixel_t expected_rgb[$];

    int errors     = 0;
    int sent_cnt   = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int calm_left  = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    bit tail_phase = 1'b0;

    // Idling is allowed outside calm stretches, the output hold-off and the tail
    wire idle_ok = !tail_phase && (calm_left == 0) && (hold_left == 0);

    hsv_to_rgb_converter DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .hue       (hue),
        .sat       (sat),
        .val       (val),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Compute the RGB pixel for one HSV pixel with the six-sector rule.
    function automatic rgb_pixel_t predict_rgb(logic signed [15:0] h_in,
                                               h2r_pkg::fix_t s_in,
                                               h2r_pkg::fix_t v_in);
        int               h;
        int unsigned      s, v, hu, rem, f, p, q, t;
        int unsigned      r, g, b;
        h2r_pkg::sector_t sec;
        rgb_pixel_t       c;
        // Wrap the angle into one turn; % truncates toward zero, so fix negatives
        h = int'(h_in);
        h = h % int'(h2r_pkg::FULL_TURN);
        if (h < 0)
            h += int'(h2r_pkg::FULL_TURN);
        // Saturate both inputs to 1.0
        s = (s_in > h2r_pkg::ONE_FIX) ? 32'(h2r_pkg::ONE_FIX) : 32'(s_in);
        v = (v_in > h2r_pkg::ONE_FIX) ? 32'(h2r_pkg::ONE_FIX) : 32'(v_in);
        if (s == 0)
        begin
            // Grey at the value level
            r = v;
            g = v;
            b = v;
        end
        else
        begin
            hu  = unsigned'(h);
            sec = h2r_pkg::sector_t'(hu / 32'(h2r_pkg::SECTOR_SIZE));
            rem = hu % 32'(h2r_pkg::SECTOR_SIZE);
            f   = (rem * 4096) / 32'(h2r_pkg::SECTOR_SIZE);
            p   = (v * (4096 - s)) >> 12;
            q   = (v * (4096 - ((s * f) >> 12))) >> 12;
            t   = (v * (4096 - ((s * (4096 - f)) >> 12))) >> 12;
            case (sec)
                h2r_pkg::SECTOR_0:
                begin
                    r = v; g = t; b = p;
                end
                h2r_pkg::SECTOR_1:
                begin
                    r = q; g = v; b = p;
                end
                h2r_pkg::SECTOR_2:
                begin
                    r = p; g = v; b = t;
                end
                h2r_pkg::SECTOR_3:
                begin
                    r = p; g = q; b = v;
                end
                h2r_pkg::SECTOR_4:
                begin
                    r = t; g = p; b = v;
                end
                default:
                begin
                    r = v; g = p; b = q;
                end
            endcase
        end
        c.red   = h2r_pkg::fix_t'(r);
        c.green = h2r_pkg::fix_t'(g);
        c.blue  = h2r_pkg::fix_t'(b);
        return c;
    endfunction

    task automatic add_pixel(int h, int s, int v);
        hsv_pixel_t px;
        px.hue = 16'(h);
        px.sat = 13'(s);
        px.val = 13'(v);
        pending_pixels.push_back(px);
    endtask

    // Print one line per mismatch and count it.
    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Input side: offer pending pixels, hold the payload while the block stalls,
    // and record the expected result at every input transfer.
    always @(posedge clk or negedge rst_n)
    begin : drive_pixels
        hsv_pixel_t px;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            hue      <= '0;
            sat      <= '0;
            val      <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_rgb.push_back(predict_rgb(hue, sat, val));
                sent_cnt <= sent_cnt + 1;
            end

            tail_phase <= (pending_pixels.size() <= TAIL_PIXELS);

            // Drop into calm stretches with no idling now and then
            if (calm_left != 0)
                calm_left <= calm_left - 1;
            else if ($urandom_range(0, 99) == 0)
                calm_left <= $urandom_range(50, 300);

            if (in_valid && !in_ready)
            begin
                // Hold: the offered pixel has not been taken yet
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() == 0)
                in_valid <= 1'b0;
            else if (idle_ok && $urandom_range(0, 5) == 0)
            begin
                // Start an idle burst of random length
                gap_left <= $urandom_range(0, 18);
                in_valid <= 1'b0;
            end
            else
            begin
                px = pending_pixels.pop_front();
                hue      <= px.hue;
                sat      <= px.sat;
                val      <= px.val;
                in_valid <= 1'b1;
            end
        end
    end

    // Long output hold-off, counted here: fire once after enough transfers so
    // that the pipeline fills and the block must lower in_ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && sent_cnt >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Output side: check every output transfer against the oldest expectation,
    // and stall the receiver in random bursts.
    always @(posedge clk or negedge rst_n)
    begin : check_pixels
        rgb_pixel_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rgb.size() == 0)
                    report_mismatch("unexpected result, red", int'(red), -1);
                else
                begin
                    want = expected_rgb.pop_front();
                    if (red !== want.red)
                        report_mismatch("red", int'(red), int'(want.red));
                    if (green !== want.green)
                        report_mismatch("green", int'(green), int'(want.green));
                    if (blue !== want.blue)
                        report_mismatch("blue", int'(blue), int'(want.blue));
                end
            end

            if (hold_left != 0)
                out_ready <= 1'b0;
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (idle_ok && $urandom_range(0, 5) == 0)
            begin
                // Start a stall burst of random length
                stall_left <= $urandom_range(0, 18);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Fill the stimulus queue, release reset, wait for the pipeline to drain.
    initial
    begin : stimulus
        int k;
        int pick;
        int base;

        // Sector boundaries at full saturation and value
        add_pixel(0, 4096, 4096);
        add_pixel(3839, 4096, 4096);
        add_pixel(3840, 4096, 4096);
        add_pixel(7679, 4096, 4096);
        add_pixel(7680, 4096, 4096);
        add_pixel(11520, 4096, 4096);
        add_pixel(15360, 4096, 4096);
        add_pixel(19200, 4096, 4096);
        add_pixel(23039, 4096, 4096);
        // Exactly a full turn, negative hues and hues past one turn
        add_pixel(23040, 4096, 4096);
        add_pixel(-1, 4096, 4096);
        add_pixel(-23040, 4096, 4096);
        add_pixel(-23039, 2048, 4096);
        add_pixel(23041, 4096, 4096);
        add_pixel(-23041, 4096, 4096);
        add_pixel(32767, 4096, 4096);
        add_pixel(-32768, 4096, 4096);
        // Grey, black, and saturation and value above 1.0
        add_pixel(9000, 0, 3000);
        add_pixel(9000, 4096, 0);
        add_pixel(1920, 8191, 8191);
        add_pixel(5000, 4097, 4097);
        add_pixel(12345, 1, 4096);
        add_pixel(20000, 2048, 2048);
        add_pixel(-7000, 3000, 1234);

        for (k = 0; k < RANDOM_PIXELS; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                add_pixel(int'($urandom_range(0, 46080)) - 23040,
                          int'($urandom_range(0, 4096)),
                          int'($urandom_range(0, 4096)));
            else if (pick == 7)
            begin
                // Land close to a sector edge, either sign
                base = (int'($urandom_range(0, 12)) - 6) * int'(h2r_pkg::SECTOR_SIZE);
                add_pixel(base + int'($urandom_range(0, 4)) - 2,
                          int'($urandom_range(0, 4096)),
                          int'($urandom_range(0, 4096)));
            end
            else
                add_pixel(int'($urandom()), int'($urandom_range(0, 8191)),
                          int'($urandom_range(0, 8191)));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_rgb.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
